@@ rtl/itp_pkg.sv @@
// ----------------------------------------------------------------------------
// itp_pkg
// Shared types, constants and lookup functions for the infix-to-postfix core.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Default operator stack depth
  localparam int unsigned StackDepth = 16;

  // Character and status field widths
  localparam int unsigned SymW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CodeW   = 3;

  // ASCII characters the converter recognizes
  localparam logic [SymW-1:0] ChLParen = 8'h28;  // '('
  localparam logic [SymW-1:0] ChRParen = 8'h29;  // ')'
  localparam logic [SymW-1:0] ChPlus   = 8'h2B;  // '+'
  localparam logic [SymW-1:0] ChMinus  = 8'h2D;  // '-'
  localparam logic [SymW-1:0] ChStar   = 8'h2A;  // '*'
  localparam logic [SymW-1:0] ChSlash  = 8'h2F;  // '/'
  localparam logic [SymW-1:0] ChPct    = 8'h25;  // '%'
  localparam logic [SymW-1:0] ChCaret  = 8'h5E;  // '^'
  localparam logic [SymW-1:0] ChZero   = 8'h30;  // '0'
  localparam logic [SymW-1:0] ChNine   = 8'h39;  // '9'

  // Stacked operator codes
  typedef enum logic [CodeW-1:0] {
    OP_LPAREN = 3'd0,
    OP_ADD    = 3'd1,
    OP_SUB    = 3'd2,
    OP_MUL    = 3'd3,
    OP_DIV    = 3'd4,
    OP_MOD    = 3'd5,
    OP_POW    = 3'd6,
    OP_NONE   = 3'd7
  } op_code_e;

  // End word status
  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNMATCHED = 2'd2
  } status_e;

  // Character to operator code; OP_NONE for anything else
  function automatic op_code_e op_decode(logic [SymW-1:0] ch);
    op_code_e code;
    case (ch)
      ChPlus:  code = OP_ADD;
      ChMinus: code = OP_SUB;
      ChStar:  code = OP_MUL;
      ChSlash: code = OP_DIV;
      ChPct:   code = OP_MOD;
      ChCaret: code = OP_POW;
      default: code = OP_NONE;
    endcase
    return code;
  endfunction

  // Operator code back to its character
  function automatic logic [SymW-1:0] op_char(op_code_e code);
    logic [SymW-1:0] ch;
    case (code)
      OP_LPAREN: ch = ChLParen;
      OP_ADD:    ch = ChPlus;
      OP_SUB:    ch = ChMinus;
      OP_MUL:    ch = ChStar;
      OP_DIV:    ch = ChSlash;
      OP_MOD:    ch = ChPct;
      OP_POW:    ch = ChCaret;
      default:   ch = '0;
    endcase
    return ch;
  endfunction

  // Precedence: ^ 3, * / % 2, + - 1, '(' 0
  function automatic logic [1:0] op_prec(op_code_e code);
    logic [1:0] p;
    case (code)
      OP_ADD, OP_SUB:         p = 2'd1;
      OP_MUL, OP_DIV, OP_MOD: p = 2'd2;
      OP_POW:                 p = 2'd3;
      default:                p = 2'd0;
    endcase
    return p;
  endfunction

endpackage

@@ rtl/itp_stream_if.sv @@
// ----------------------------------------------------------------------------
// itp_in_if / itp_out_if
// Valid/ready channels for input characters and postfix output words.
// ----------------------------------------------------------------------------
interface itp_in_if;
  logic                      valid;
  logic                      ready;
  logic [itp_pkg::SymW-1:0]  symbol;
  logic                      is_final;

  modport source (output valid, output symbol, output is_final, input ready);
  modport sink   (input valid, input symbol, input is_final, output ready);
endinterface

interface itp_out_if;
  logic                         valid;
  logic                         ready;
  logic [itp_pkg::SymW-1:0]     out_symbol;
  logic                         has_symbol;
  logic                         end_of_output;
  logic [itp_pkg::StatusW-1:0]  status;

  modport source (output valid, output out_symbol, output has_symbol,
                  output end_of_output, output status, input ready);
  modport sink   (input valid, input out_symbol, input has_symbol,
                  input end_of_output, input status, output ready);
endinterface

@@ rtl/itp_ram.sv @@
// ----------------------------------------------------------------------------
// itp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module itp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/infix_to_postfix_converter_core.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// Shunting-yard converter: infix characters in, postfix words out.
// ----------------------------------------------------------------------------
// One input word is one ASCII character; the final character of an expression
// carries is_final and is followed on the output by an end word whose status
// reports the first stack overflow or unmatched ')' seen in that expression.
// Operators sit in a RAM stack of STACK_DEPTH entries with a registered read.
// A digit is emitted from S_DIGIT, an ignored character is dropped in S_IDLE
// and '(' is pushed in S_PUSH. An operator, ')' and the final character run
// the stack loop: S_RD reads the top into the RAM read register and S_EVAL
// pops it when it qualifies, one RAM read per popped entry; an operator is
// then pushed in S_PUSH and the final character ends with the end word from
// S_END. Output stalls hold S_DIGIT, S_EVAL and S_END. The output register
// lets the next character be taken while the last word still waits.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
  parameter int unsigned STACK_DEPTH = itp_pkg::StackDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  itp_in_if.sink    in_i,
  itp_out_if.source out_o
);

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIGIT,
    S_RD,
    S_EVAL,
    S_PUSH,
    S_END
  } state_e;

  // What the pop loop is doing
  typedef enum logic [1:0] {
    M_OP,
    M_CLOSE,
    M_FLUSH
  } mode_e;

  state_e                      state_q, state_d;
  mode_e                       mode_q, mode_d;
  logic [itp_pkg::SymW-1:0]    sym_q, sym_d;
  itp_pkg::op_code_e           code_q, code_d;
  logic                        fin_q, fin_d;
  logic [CntW-1:0]             count_q, count_d;
  itp_pkg::status_e            status_q, status_d;

  logic                        out_valid_q, out_valid_d;
  logic [itp_pkg::SymW-1:0]    out_sym_q, out_sym_d;
  logic                        out_has_q, out_has_d;
  logic                        out_end_q, out_end_d;
  itp_pkg::status_e            out_st_q, out_st_d;

  logic                        ram_we, ram_re;
  logic [AddrW-1:0]            ram_waddr, ram_raddr;
  logic [itp_pkg::CodeW-1:0]   ram_rdata;
  logic [CntW-1:0]             count_m1;
  itp_pkg::op_code_e           top;
  itp_pkg::op_code_e           in_code;
  logic                        in_acc, out_pop, can_emit;
  logic                        emit, emit_end;
  logic [itp_pkg::SymW-1:0]    emit_sym;
  logic                        pop_it;
  logic                        is_digit;

  // Operator stack
  itp_ram #(
    .Width (itp_pkg::CodeW),
    .Depth (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (code_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign count_m1  = count_q - CntW'(1);
  assign ram_raddr = count_m1[AddrW-1:0];
  assign ram_waddr = count_q[AddrW-1:0];
  assign top       = itp_pkg::op_code_e'(ram_rdata);

  // Handshakes
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_pop    = out_valid_q && out_o.ready;
  assign can_emit   = !out_valid_q || out_pop;

  assign in_code  = itp_pkg::op_decode(in_i.symbol);
  assign is_digit = (in_i.symbol >= itp_pkg::ChZero) && (in_i.symbol <= itp_pkg::ChNine);

  // Pop rule: higher or equal precedence, but '^' stays on a tie
  always_comb begin
    pop_it = (itp_pkg::op_prec(top) >= itp_pkg::op_prec(code_q)) &&
             !((itp_pkg::op_prec(top) == itp_pkg::op_prec(code_q)) &&
               (top == itp_pkg::OP_POW));
  end

  // Control sequencer
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    sym_d    = sym_q;
    code_d   = code_q;
    fin_d    = fin_q;
    count_d  = count_q;
    status_d = status_q;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    emit     = 1'b0;
    emit_end = 1'b0;
    emit_sym = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          sym_d = in_i.symbol;
          fin_d = in_i.is_final;
          if (is_digit) begin
            state_d = S_DIGIT;
          end else if (in_code != itp_pkg::OP_NONE) begin
            code_d  = in_code;
            mode_d  = M_OP;
            state_d = S_RD;
          end else if (in_i.symbol == itp_pkg::ChLParen) begin
            code_d  = itp_pkg::OP_LPAREN;
            state_d = S_PUSH;
          end else if (in_i.symbol == itp_pkg::ChRParen) begin
            mode_d  = M_CLOSE;
            state_d = S_RD;
          end else if (in_i.is_final) begin
            mode_d  = M_FLUSH;
            state_d = S_RD;
          end
        end
      end

      S_DIGIT: begin
        if (can_emit) begin
          emit     = 1'b1;
          emit_sym = sym_q;
          if (fin_q) begin
            mode_d  = M_FLUSH;
            state_d = S_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      // Fetch top of stack, or finish the loop on an empty stack
      S_RD: begin
        if (count_q == '0) begin
          case (mode_q)
            M_OP: begin
              state_d = S_PUSH;
            end
            M_CLOSE: begin
              if (status_q == itp_pkg::ST_OK) begin
                status_d = itp_pkg::ST_UNMATCHED;
              end
              if (fin_q) begin
                mode_d  = M_FLUSH;
                state_d = S_RD;
              end else begin
                state_d = S_IDLE;
              end
            end
            default: begin
              state_d = S_END;
            end
          endcase
        end else begin
          ram_re  = 1'b1;
          state_d = S_EVAL;
        end
      end

      // Top of stack is in the read register
      S_EVAL: begin
        case (mode_q)
          M_OP: begin
            if (!pop_it) begin
              state_d = S_PUSH;
            end else if (can_emit) begin
              emit     = 1'b1;
              emit_sym = itp_pkg::op_char(top);
              count_d  = count_m1;
              state_d  = S_RD;
            end
          end
          M_CLOSE: begin
            if (top == itp_pkg::OP_LPAREN) begin
              count_d = count_m1;
              if (fin_q) begin
                mode_d  = M_FLUSH;
                state_d = S_RD;
              end else begin
                state_d = S_IDLE;
              end
            end else if (can_emit) begin
              emit     = 1'b1;
              emit_sym = itp_pkg::op_char(top);
              count_d  = count_m1;
              state_d  = S_RD;
            end
          end
          default: begin
            if (can_emit) begin
              emit     = 1'b1;
              emit_sym = itp_pkg::op_char(top);
              count_d  = count_m1;
              state_d  = S_RD;
            end
          end
        endcase
      end

      // Push code_q; a full stack drops it and flags overflow if no error is yet recorded
      S_PUSH: begin
        if (count_q < CntW'(STACK_DEPTH)) begin
          ram_we  = 1'b1;
          count_d = count_q + CntW'(1);
        end else if (status_q == itp_pkg::ST_OK) begin
          status_d = itp_pkg::ST_OVERFLOW;
        end
        if (fin_q) begin
          mode_d  = M_FLUSH;
          state_d = S_RD;
        end else begin
          state_d = S_IDLE;
        end
      end

      // End word, then clear for the next expression
      S_END: begin
        if (can_emit) begin
          emit     = 1'b1;
          emit_end = 1'b1;
          count_d  = '0;
          status_d = itp_pkg::ST_OK;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_has_d   = out_has_q;
    out_end_d   = out_end_q;
    out_st_d    = out_st_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_sym_d   = emit_sym;
      out_has_d   = !emit_end;
      out_end_d   = emit_end;
      out_st_d    = emit_end ? status_q : itp_pkg::ST_OK;
    end else if (out_pop) begin
      out_valid_d = 1'b0;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= M_OP;
      sym_q       <= '0;
      code_q      <= itp_pkg::OP_NONE;
      fin_q       <= 1'b0;
      count_q     <= '0;
      status_q    <= itp_pkg::ST_OK;
      out_valid_q <= 1'b0;
      out_sym_q   <= '0;
      out_has_q   <= 1'b0;
      out_end_q   <= 1'b0;
      out_st_q    <= itp_pkg::ST_OK;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      sym_q       <= sym_d;
      code_q      <= code_d;
      fin_q       <= fin_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      out_sym_q   <= out_sym_d;
      out_has_q   <= out_has_d;
      out_end_q   <= out_end_d;
      out_st_q    <= out_st_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_symbol    = out_sym_q;
  assign out_o.has_symbol    = out_has_q;
  assign out_o.end_of_output = out_end_q;
  assign out_o.status        = out_st_q;

endmodule
